FILE: rtl/core/irkat_pkg.sv
// irkat_pkg: types, codes and sizing constants of the ir key action table engine
// used by the engine, the top and the verification files; depends on nothing
`default_nettype none

package irkat_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_MAX    = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
  localparam int CNT_W       = $clog2(SCAN_MAX + 1);

  // input opcodes
  localparam logic [1:0] OP_CODE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // entry modes
  localparam logic [1:0] KM_TOGGLE = 2'd0;
  localparam logic [1:0] KM_HOLD   = 2'd1;
  localparam logic [1:0] KM_STEP   = 2'd2;
  localparam logic [1:0] KM_NONE   = 2'd3;

  // result actions
  localparam logic [1:0] ACT_ON     = 2'd0;
  localparam logic [1:0] ACT_OFF    = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;
  localparam logic [1:0] ACT_PWM    = 2'd3;

  // key events
  localparam logic [1:0] EV_PRESSED    = 2'd0;
  localparam logic [1:0] EV_AUTOREPEAT = 2'd1;
  localparam logic [1:0] EV_RELEASED   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS    = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_REP_A   = 2'd2;
  localparam logic [1:0] CFG_REP_B   = 2'd3;

  typedef enum logic [1:0] {
    KEY_IDLE,
    KEY_DOWN,
    KEY_AUTO
  } key_state_t;

  typedef enum logic [2:0] {
    ST_READY,
    ST_DISPATCH,
    ST_SCAN,
    ST_ACT,
    ST_TGT,
    ST_EMIT
  } eng_state_t;

  typedef struct packed {
    logic [31:0] code;
    logic [7:0]  pin;
    logic [1:0]  mode;
    logic [15:0] value;
    logic [4:0]  tgt_idx;
    logic [15:0] step;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [5:0]  rows_in_use;
    logic [15:0] release_timeout;
    logic [31:0] repeat_code_a;
    logic [31:0] repeat_code_b;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  pin;
    logic [15:0] level;
    logic [4:0]  key_index;
    logic [1:0]  key_event;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/irkat_ifs.sv
// irkat_ifs: valid/ready channel interfaces of the block (input, result, configuration)
// depends on nothing
`default_nettype none

interface irkat_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [31:0]       ir_code;
  logic [4:0]        entry_index;
  logic [7:0]        entry_pin;
  logic [1:0]        entry_mode;
  logic signed [15:0] entry_value;
  logic [4:0]        entry_ref;
  logic signed [15:0] entry_step;

  modport source (output valid, opcode, ir_code, entry_index, entry_pin, entry_mode,
                  entry_value, entry_ref, entry_step, input ready);
  modport sink (input valid, opcode, ir_code, entry_index, entry_pin, entry_mode,
                entry_value, entry_ref, entry_step, output ready);
endinterface

interface irkat_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  pin;
  logic [15:0] level;
  logic [4:0]  key_index;
  logic [1:0]  key_event;

  modport source (output valid, action, pin, level, key_index, key_event, input ready);
  modport sink (input valid, action, pin, level, key_index, key_event, output ready);
endinterface

interface irkat_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/irkat_table_ram.sv
// irkat_table_ram: single-port synchronous ram, one access per cycle, registered read
// generic; no package dependency
`default_nettype none

module irkat_table_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/irkat_engine.sv
// irkat_engine: press state machine, table search and action sequencer
// uses irkat_pkg, irkat_ifs and irkat_table_ram
`default_nettype none

module irkat_engine
  import irkat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  irkat_in_if.sink     in_ch,
  output logic         res_vld,
  input  wire logic    res_rdy,
  output result_t      res
);

  eng_state_t state_r, state_nxt;
  key_state_t key_r, key_nxt;
  logic [4:0]       held_r, held_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      code_r, code_nxt;
  logic [4:0]       wr_idx_r, wr_idx_nxt;
  entry_t           wr_ent_r, wr_ent_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [1:0]       ev_r, ev_nxt;
  logic [15:0]      step_r, step_nxt;
  logic [4:0]       tgt_r, tgt_nxt;
  result_t          res_r, res_nxt;

  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  entry_t            ram_wdata, rd;

  logic [CNT_W-1:0] limit;
  logic             hit, is_rep, timed_out, act_emit;
  logic [15:0]      elapsed_inc, new_val;
  logic [4:0]       tgt_sel;

  irkat_table_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd)
  );

  // search bound saturates at the table size
  assign limit = ({3'b000, cfg.rows_in_use} > 9'(SCAN_MAX)) ? CNT_W'(SCAN_MAX)
                                                           : CNT_W'(cfg.rows_in_use);
  assign hit = pend_r && (rd.code == code_r);
  assign is_rep = (code_r == cfg.repeat_code_a) || (code_r == cfg.repeat_code_b);
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign timed_out = elapsed_inc > cfg.release_timeout;
  assign tgt_sel = (rd.tgt_idx == 5'd0 || {4'b0000, rd.tgt_idx} >= 9'(TABLE_DEPTH))
                   ? held_r : rd.tgt_idx;
  assign new_val = rd.value + step_r;
  assign act_emit = ((rd.mode == KM_TOGGLE) && (ev_r == EV_PRESSED)) ||
                    ((rd.mode == KM_HOLD) && (ev_r != EV_AUTOREPEAT));

  assign in_ch.ready = (state_r == ST_READY);
  assign res_vld = (state_r == ST_EMIT);
  assign res = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_READY: begin
        if (in_ch.valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_nxt = ST_READY;
        if (op_r == OP_CODE) begin
          if (key_r == KEY_IDLE) state_nxt = ST_SCAN;
          else if (key_r == KEY_AUTO || is_rep) state_nxt = ST_ACT;
        end else if (op_r == OP_TICK) begin
          if (key_r != KEY_IDLE && timed_out) state_nxt = ST_ACT;
        end
      end
      ST_SCAN: begin
        if (hit) state_nxt = ST_ACT;
        else if (scan_r < limit) state_nxt = ST_SCAN;
        else state_nxt = ST_READY;
      end
      ST_ACT: begin
        if (rd.mode == KM_STEP) state_nxt = ST_TGT;
        else if (act_emit) state_nxt = ST_EMIT;
        else state_nxt = ST_READY;
      end
      ST_TGT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_rdy) state_nxt = ST_READY;
      end
      default: state_nxt = ST_READY;
    endcase
  end

  always_comb begin
    key_nxt     = key_r;
    held_nxt    = held_r;
    elapsed_nxt = elapsed_r;
    op_nxt      = op_r;
    code_nxt    = code_r;
    wr_idx_nxt  = wr_idx_r;
    wr_ent_nxt  = wr_ent_r;
    scan_nxt    = scan_r;
    pend_nxt    = pend_r;
    ev_nxt      = ev_r;
    step_nxt    = step_r;
    tgt_nxt     = tgt_r;
    res_nxt     = res_r;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = ADDR_W'(held_r);
    ram_wdata   = rd;
    unique case (state_r)
      ST_READY: begin
        if (in_ch.valid) begin
          op_nxt             = in_ch.opcode;
          code_nxt           = in_ch.ir_code;
          wr_idx_nxt         = in_ch.entry_index;
          wr_ent_nxt.code    = in_ch.ir_code;
          wr_ent_nxt.pin     = in_ch.entry_pin;
          wr_ent_nxt.mode    = in_ch.entry_mode;
          wr_ent_nxt.value   = in_ch.entry_value;
          wr_ent_nxt.tgt_idx = in_ch.entry_ref;
          wr_ent_nxt.step    = in_ch.entry_step;
        end
      end
      ST_DISPATCH: begin
        case (op_r)
          OP_CODE: begin
            elapsed_nxt = 16'd0;
            scan_nxt    = '0;
            pend_nxt    = 1'b0;
            ev_nxt      = EV_AUTOREPEAT;
            if (key_r == KEY_AUTO) begin
              ram_en = 1'b1;
            end else if (key_r == KEY_DOWN && is_rep) begin
              key_nxt = KEY_AUTO;
              ram_en  = 1'b1;
            end
          end
          OP_TICK: begin
            if (key_r != KEY_IDLE) begin
              elapsed_nxt = elapsed_inc;
              if (timed_out) begin
                key_nxt = KEY_IDLE;
                ev_nxt  = EV_RELEASED;
                ram_en  = 1'b1;
              end
            end
          end
          OP_WRITE: begin
            if ({4'b0000, wr_idx_r} < 9'(TABLE_DEPTH)) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = ADDR_W'(wr_idx_r);
              ram_wdata = wr_ent_r;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // compare the entry read last cycle while fetching the next one
        if (hit) begin
          key_nxt  = KEY_DOWN;
          held_nxt = 5'(scan_r - 1'b1);
          ev_nxt   = EV_PRESSED;
          pend_nxt = 1'b0;
        end else if (scan_r < limit) begin
          ram_en   = 1'b1;
          ram_addr = ADDR_W'(scan_r);
          scan_nxt = scan_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_ACT: begin
        res_nxt.pin       = rd.pin;
        res_nxt.key_index = held_r;
        res_nxt.key_event = ev_r;
        if (rd.mode == KM_TOGGLE) begin
          res_nxt.action = ACT_TOGGLE;
          res_nxt.level  = rd.value;
        end else begin
          res_nxt.action = (ev_r == EV_PRESSED) ? ACT_ON : ACT_OFF;
          res_nxt.level  = 16'd0;
        end
        if (rd.mode == KM_STEP) begin
          step_nxt = rd.step;
          tgt_nxt  = tgt_sel;
          ram_en   = 1'b1;
          ram_addr = ADDR_W'(tgt_sel);
        end
      end
      ST_TGT: begin
        // step the target value and write the entry back
        ram_en          = 1'b1;
        ram_we          = 1'b1;
        ram_addr        = ADDR_W'(tgt_r);
        ram_wdata       = rd;
        ram_wdata.value = new_val;
        res_nxt.action    = ACT_PWM;
        res_nxt.pin       = rd.pin;
        res_nxt.level     = new_val;
        res_nxt.key_index = held_r;
        res_nxt.key_event = ev_r;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_READY;
      key_r     <= KEY_IDLE;
      held_r    <= 5'd0;
      elapsed_r <= 16'd0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      key_r     <= key_nxt;
      held_r    <= held_nxt;
      elapsed_r <= elapsed_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    code_r   <= code_nxt;
    wr_idx_r <= wr_idx_nxt;
    wr_ent_r <= wr_ent_nxt;
    scan_r   <= scan_nxt;
    ev_r     <= ev_nxt;
    step_r   <= step_nxt;
    tgt_r    <= tgt_nxt;
    res_r    <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ir_key_action_table_engine_top.sv
// ir key action table engine: IR codes, ms ticks and key-table writes in, pin actions out.
//
// channels: in_ch carries requests (opcode 0 code, 1 tick, 2 table write),
// out_ch carries at most one action per request, cfg_ch writes the four
// configuration registers (0 rows searched, 1 release timeout, 2 and 3 repeat
// codes); cfg_ch is always ready; it is to be written only while the block is
// idle, which the block itself does not enforce. a tick, a write or a held code
// that starts nothing passes through dispatch only; reading the held entry adds
// the action state, a toggle or hold action adds the emit state, and a repeat key
// adds the target state (it reads and writes back the target entry). a code while
// idle scans the table one entry per cycle through the single-port table ram,
// back to ready when no searched row matches; a match leads on to the states above.
// the next request is accepted once the result sits in the output register,
// so the ram port and the scan set the rate.
// reset (synchronous, active low) idles the press machine, clears the timer
// and loads register defaults; the table holds garbage until written.
// when out_ch stalls, one result is held in the output register and one more
// waits in the engine; requests then stop being accepted.
`default_nettype none

module ir_key_action_table_engine_top
  import irkat_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  irkat_in_if.sink    in_ch,
  irkat_out_if.source out_ch,
  irkat_cfg_if.sink   cfg_ch
);

  cfg_t    cfg_r, cfg_nxt;
  logic    out_vld_r, out_vld_nxt;
  result_t out_r, out_nxt;
  logic    res_vld, res_rdy;
  result_t res;

  irkat_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .res_vld (res_vld),
    .res_rdy (res_rdy),
    .res     (res)
  );

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_ROWS:    cfg_nxt.rows_in_use     = cfg_ch.wdata[5:0];
        CFG_TIMEOUT: cfg_nxt.release_timeout = cfg_ch.wdata[15:0];
        CFG_REP_A:   cfg_nxt.repeat_code_a   = cfg_ch.wdata;
        CFG_REP_B:   cfg_nxt.repeat_code_b   = cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // output register, refilled in the cycle it drains
  assign res_rdy = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (out_ch.ready) out_vld_nxt = 1'b0;
    if (res_vld && res_rdy) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.action    = out_r.action;
  assign out_ch.pin       = out_r.pin;
  assign out_ch.level     = out_r.level;
  assign out_ch.key_index = out_r.key_index;
  assign out_ch.key_event = out_r.key_event;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use     <= 6'd0;
      cfg_r.release_timeout <= 16'd150;
      cfg_r.repeat_code_a   <= 32'hFFFF_FFFF;
      cfg_r.repeat_code_b   <= 32'd0;
      out_vld_r             <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: verif/key_action_monitor.sv
// key_action_monitor: watches the request, action and register channels of the ir key action
// table engine, predicts each action from its own copy of the press machine and key table
// and compares it field by field; depends on irkat_pkg and irkat_ifs
module key_action_monitor
  import irkat_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  irkat_in_if  req_bus,
  irkat_out_if act_bus,
  irkat_cfg_if reg_bus,
  output int   mismatches,
  output int   pending
);

  cfg_t        regs;
  key_state_t  key_st;
  logic [4:0]  held_idx;
  logic [15:0] quiet_ticks;
  entry_t      key_copy [TABLE_DEPTH];
  result_t     actions_due [$];

  // action for one key event; repeat keys step their target value in place
  function automatic bit key_action(input logic [1:0] ev, input logic [4:0] idx,
                                    output result_t res);
    int tgt;
    res = '0;
    case (key_copy[idx].mode)
      KM_TOGGLE: begin
        if (ev != EV_PRESSED) return 0;
        res.action = ACT_TOGGLE;
        res.pin    = key_copy[idx].pin;
        res.level  = key_copy[idx].value;
      end
      KM_HOLD: begin
        if (ev == EV_AUTOREPEAT) return 0;
        res.action = (ev == EV_PRESSED) ? ACT_ON : ACT_OFF;
        res.pin    = key_copy[idx].pin;
      end
      KM_STEP: begin
        tgt = key_copy[idx].tgt_idx;
        if (tgt == 0 || tgt >= TABLE_DEPTH) tgt = idx;
        key_copy[tgt].value = key_copy[tgt].value + key_copy[idx].step;
        res.action = ACT_PWM;
        res.pin    = key_copy[tgt].pin;
        res.level  = key_copy[tgt].value;
      end
      default: return 0;
    endcase
    res.key_index = idx;
    res.key_event = ev;
    return 1;
  endfunction

  function automatic bit predict_request(input logic [1:0] op, input logic [31:0] code,
                                         input logic [4:0] windex, input entry_t wentry,
                                         output result_t res);
    int scan_len;
    res = '0;
    case (op)
      OP_CODE: begin
        quiet_ticks = '0;
        if (key_st == KEY_IDLE) begin
          scan_len = (regs.rows_in_use > SCAN_MAX) ? SCAN_MAX : regs.rows_in_use;
          // lowest matching entry wins
          for (int i = 0; i < scan_len; i++) begin
            if (key_copy[i].code == code) begin
              key_st   = KEY_DOWN;
              held_idx = 5'(i);
              return key_action(EV_PRESSED, held_idx, res);
            end
          end
          return 0;
        end
        if (key_st == KEY_DOWN) begin
          if (code == regs.repeat_code_a || code == regs.repeat_code_b) begin
            key_st = KEY_AUTO;
            return key_action(EV_AUTOREPEAT, held_idx, res);
          end
          return 0;
        end
        // in autorepeat any code is a repeat
        return key_action(EV_AUTOREPEAT, held_idx, res);
      end
      OP_TICK: begin
        if (key_st == KEY_IDLE) return 0;
        if (quiet_ticks != 16'hFFFF) quiet_ticks++;
        if (quiet_ticks > regs.release_timeout) begin
          key_st = KEY_IDLE;
          return key_action(EV_RELEASED, held_idx, res);
        end
        return 0;
      end
      OP_WRITE: begin
        if (windex < TABLE_DEPTH) key_copy[windex] = wentry;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t due;
    result_t seen;
    result_t fresh;
    entry_t  wr;
    if (!rst_n) begin
      regs.rows_in_use     = '0;
      regs.release_timeout = 16'd150;
      regs.repeat_code_a   = '1;
      regs.repeat_code_b   = '0;
      key_st      = KEY_IDLE;
      held_idx    = '0;
      quiet_ticks = '0;
      mismatches  = 0;
      actions_due.delete();
    end else begin
      if (reg_bus.valid && reg_bus.ready) begin
        case (reg_bus.reg_index)
          CFG_ROWS:    regs.rows_in_use     = reg_bus.wdata[5:0];
          CFG_TIMEOUT: regs.release_timeout = reg_bus.wdata[15:0];
          CFG_REP_A:   regs.repeat_code_a   = reg_bus.wdata;
          CFG_REP_B:   regs.repeat_code_b   = reg_bus.wdata;
          default: ;
        endcase
      end
      // actions first: one can never answer a request taken at the same edge
      if (act_bus.valid && act_bus.ready) begin
        seen = '{act_bus.action, act_bus.pin, act_bus.level, act_bus.key_index,
                 act_bus.key_event};
        if (actions_due.size() == 0) begin
          $error("action with none outstanding: action %0h pin %0h key_index %0d",
                 seen.action, seen.pin, seen.key_index);
          mismatches++;
        end else begin
          due = actions_due.pop_front();
          check_field("action", due.action, seen.action);
          check_field("pin", due.pin, seen.pin);
          check_field("level", due.level, seen.level);
          check_field("key_index", due.key_index, seen.key_index);
          check_field("key_event", due.key_event, seen.key_event);
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        wr.code    = req_bus.ir_code;
        wr.pin     = req_bus.entry_pin;
        wr.mode    = req_bus.entry_mode;
        wr.value   = req_bus.entry_value;
        wr.tgt_idx = req_bus.entry_ref;
        wr.step    = req_bus.entry_step;
        if (predict_request(req_bus.opcode, req_bus.ir_code, req_bus.entry_index, wr, fresh))
          actions_due.push_back(fresh);
      end
    end
    pending = actions_due.size();
  end

endmodule

FILE: verif/testbench.sv
// testbench: drives key-table writes, IR codes and ticks into the ir key action table engine
// through several register settings and hands checking to key_action_monitor;
// depends on irkat_pkg, irkat_ifs, the engine top and key_action_monitor
module testbench;
  import irkat_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         SETTLE_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          calm;
  int          sent_count;
  int          cycle_count;
  int          mismatches;
  int          pending;
  logic [31:0] code_of [32];
  logic [5:0]  cur_rows;
  logic [15:0] cur_timeout;
  logic [31:0] rep_a;
  logic [31:0] rep_b;

  irkat_in_if  in_ch ();
  irkat_out_if out_ch ();
  irkat_cfg_if cfg_ch ();

  ir_key_action_table_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  key_action_monitor mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_bus    (in_ch),
    .act_bus    (out_ch),
    .reg_bus    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic entry_t random_entry();
    entry_t e;
    e.code    = $urandom;
    e.pin     = 8'($urandom_range(255));
    e.mode    = 2'($urandom_range(3));
    e.value   = 16'($urandom_range(65535));
    e.tgt_idx = 5'($urandom_range(31));
    e.step    = 16'($urandom_range(65535));
    return e;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [4:0] windex, input entry_t ent);
    while (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.ir_code     <= ent.code;
    in_ch.entry_index <= windex;
    in_ch.entry_pin   <= ent.pin;
    in_ch.entry_mode  <= ent.mode;
    in_ch.entry_value <= ent.value;
    in_ch.entry_ref   <= ent.tgt_idx;
    in_ch.entry_step  <= ent.step;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // unused fields of codes and ticks carry random bits
  task automatic send_code(input logic [31:0] code);
    entry_t e;
    e = random_entry();
    e.code = code;
    send_request(OP_CODE, 5'($urandom_range(31)), e);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 5'($urandom_range(31)), random_entry());
  endtask

  task automatic write_entry(input logic [4:0] idx, input entry_t e);
    code_of[idx] = e.code;
    send_request(OP_WRITE, idx, e);
  endtask

  // wait until every action has come back and the engine has had time to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [5:0] rows, input logic [15:0] timeout,
                              input logic [31:0] a, input logic [31:0] b);
    logic [1:0]  ids [4];
    logic [31:0] vals [4];
    ids  = '{CFG_ROWS, CFG_TIMEOUT, CFG_REP_A, CFG_REP_B};
    vals = '{32'(rows), 32'(timeout), a, b};
    settle();
    for (int r = 0; r < 4; r++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= ids[r];
      cfg_ch.wdata     <= vals[r];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_rows    = rows;
    cur_timeout = timeout;
    rep_a       = a;
    rep_b       = b;
  endtask

  // press a key in range, mix repeats, stray codes, ticks, rewrites; time out if timeout <= 200
  task automatic key_session();
    int     eff;
    int     k;
    int     pick;
    entry_t e;
    eff = (cur_rows > 32) ? 32 : int'(cur_rows);
    k   = (eff > 0) ? $urandom_range(eff - 1) : 0;
    if ($urandom_range(99) < 20) begin
      pick = $urandom_range(2);
      if (pick == 0) send_request(OP_UNUSED, 5'($urandom_range(31)), random_entry());
      else if (pick == 1) send_code($urandom);
      else send_tick();
    end
    if (eff > 0) send_code(code_of[k]);
    else send_code($urandom);
    repeat ($urandom_range(6)) begin
      pick = $urandom_range(99);
      if (pick < 35) send_code(rep_a);
      else if (pick < 60) send_code(rep_b);
      else if (pick < 75) send_code($urandom);
      else if (pick < 90) send_tick();
      else begin
        e = random_entry();
        if ($urandom_range(3) == 0) e.code = code_of[$urandom_range(31)];
        // at least half of the rewrites hit the key just pressed
        write_entry(($urandom_range(1) == 1) ? 5'(k) : 5'($urandom_range(31)), e);
      end
    end
    if (cur_timeout <= 200) repeat (int'(cur_timeout) + 1 + $urandom_range(2)) send_tick();
  endtask

  initial begin
    entry_t      e;
    int          stop;
    logic [5:0]  ph_rows [6];
    logic [15:0] ph_timeout [6];
    int          ph_budget [6];
    bit          ph_calm [6];
    ph_rows    = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd20, 6'd32};
    ph_timeout = '{16'd4, 16'd0, 16'd9, 16'hFFFF, 16'd150, 16'd2};
    ph_budget  = '{250, 120, 200, 60, 330, 250};
    ph_calm    = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    calm        = 1'b0;
    sent_count  = 0;
    cur_rows    = '0;
    cur_timeout = 16'd150;
    rep_a       = '1;
    rep_b       = '0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_TICK;
    in_ch.ir_code     <= '0;
    in_ch.entry_index <= '0;
    in_ch.entry_pin   <= '0;
    in_ch.entry_mode  <= KM_NONE;
    in_ch.entry_value <= '0;
    in_ch.entry_ref   <= '0;
    in_ch.entry_step  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= CFG_ROWS;
    cfg_ch.wdata      <= '0;
    rst_n             <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: nothing searched, idle ticks and the unused opcode do nothing
    send_code($urandom);
    send_tick();
    send_request(OP_UNUSED, 5'd31, random_entry());

    // every entry gets written before any search or reference can reach it
    for (int i = 0; i < 32; i++) write_entry(5'(i), random_entry());

    program_regs(6'd32, 16'd0, 32'hFFFF_FFFF, 32'h0);
    e = random_entry();
    e.mode = KM_TOGGLE; e.pin = 8'hFF; e.value = 16'h8000; e.tgt_idx = 5'h1F;
    e.step = 16'h7FFF;
    write_entry(5'd0, e);
    e = random_entry();
    e.mode = KM_HOLD; e.pin = 8'h00; e.value = 16'h7FFF;
    write_entry(5'd1, e);
    e = random_entry();
    e.mode = KM_STEP; e.tgt_idx = 5'd0; e.value = 16'hFFFF; e.step = 16'h0001;
    write_entry(5'd2, e);
    e = random_entry();
    e.mode = KM_STEP; e.tgt_idx = 5'd31; e.step = 16'h8000;
    write_entry(5'd3, e);
    e = random_entry();
    e.mode = KM_NONE;
    write_entry(5'd4, e);
    // same code as entry 2, must lose the search
    e = random_entry();
    e.code = code_of[2]; e.mode = KM_TOGGLE;
    write_entry(5'd5, e);

    send_code(code_of[0]);
    send_tick();
    send_code(code_of[1]);
    send_code(32'hFFFF_FFFF);
    send_code($urandom);
    send_tick();
    send_code(code_of[2]);
    send_code($urandom);
    send_code(32'h0);
    send_code(code_of[2]);
    send_tick();
    send_code(code_of[3]);
    send_tick();
    send_code(code_of[4]);
    send_code(32'hFFFF_FFFF);
    send_tick();

    for (int p = 0; p < 6; p++) begin
      if (p == 1) program_regs(ph_rows[p], ph_timeout[p], 32'hFFFF_FFFF, 32'h0);
      else program_regs(ph_rows[p], ph_timeout[p], $urandom, $urandom);
      calm = ph_calm[p];
      stop = sent_count + ph_budget[p];
      while (sent_count < stop) key_session();
      calm = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
